### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/stlfr_pkg.sv
// ----------------------------------------------------------------------------
// stlfr_pkg
// types and constants of the sync / type / length frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stlfr_pkg;

  localparam logic [7:0] SYNC_FIRST       = 8'h53;
  localparam logic [7:0] SYNC_SECOND      = 8'h54;
  localparam logic [7:0] CAPACITY_DEFAULT = 8'd40;

  localparam logic [8:0] POS_TYPE      = 9'd0;
  localparam logic [8:0] POS_LENGTH    = 9'd1;
  localparam logic [8:0] HEAD_BYTES    = 9'd2;
  localparam logic [8:0] FRAME_LEN_MIN = 9'd3;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       payload_overflow;
    logic       frame_done;
    logic [7:0] msg_type;
    logic [8:0] frame_len;
    logic       checksum_ok;
    logic       in_frame;
  } result_t;

endpackage

### hw/rtl/sync_type_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_type_length_frame_receiver
// Hunts for the byte pair 'S','T', then takes a type byte, a length byte,
// that many payload bytes and one closing byte. Each input transaction
// gives exactly one output transaction: payload bytes stream out with their
// index and an overflow flag against max_payload_len, and the closing byte
// reports type, frame length and whether the byte sum after sync is zero.
// A byte is taken every clock cycle while in_stall is low; its result is
// registered in the output register, and in_stall follows out_stall only
// while that register holds a result that has not been taken. Frames with
// a bad sum are reported, never dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_type_length_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_index,
  output logic [7:0] payload_byte,
  output logic       payload_overflow,
  output logic       frame_done,
  output logic [7:0] msg_type,
  output logic [8:0] frame_len,
  output logic       checksum_ok,
  output logic       in_frame
);
  import stlfr_pkg::*;

  logic [7:0] max_payload_len;
  logic       receiving;
  logic [7:0] prev_byte;
  logic [8:0] byte_count;
  logic [7:0] bytes_left;
  logic [7:0] running_sum;
  logic [7:0] held_type;
  result_t    result;

  logic       receiving_next;
  logic [7:0] prev_byte_next;
  logic [8:0] byte_count_next;
  logic [7:0] bytes_left_next;
  logic [7:0] running_sum_next;
  logic [7:0] held_type_next;
  result_t    result_next;
  logic [8:0] payload_pos;
  logic       accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign payload_pos = byte_count - HEAD_BYTES;

  always_comb begin
    receiving_next   = receiving;
    prev_byte_next   = prev_byte;
    byte_count_next  = byte_count;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    held_type_next   = held_type;
    result_next      = '0;
    if (!receiving) begin
      if (prev_byte == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
        receiving_next   = 1'b1;
        byte_count_next  = '0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end else begin
        prev_byte_next = rx_byte;
      end
    end else begin
      running_sum_next = running_sum + rx_byte;
      priority if (byte_count == POS_TYPE) begin
        held_type_next  = rx_byte;
        byte_count_next = byte_count + 9'd1;
      end else if (byte_count == POS_LENGTH) begin
        bytes_left_next = rx_byte;
        byte_count_next = byte_count + 9'd1;
      end else if (bytes_left != 8'd0) begin
        result_next.payload_valid    = 1'b1;
        result_next.payload_index    = payload_pos[7:0];
        result_next.payload_byte     = rx_byte;
        result_next.payload_overflow = (payload_pos[7:0] >= max_payload_len);
        bytes_left_next              = bytes_left - 8'd1;
        byte_count_next              = byte_count + 9'd1;
      end else begin
        result_next.frame_done  = 1'b1;
        result_next.msg_type    = held_type;
        result_next.frame_len   = byte_count + 9'd1;
        result_next.checksum_ok = (running_sum_next == 8'd0);
        receiving_next          = 1'b0;
        prev_byte_next          = '0;
      end
    end
    result_next.in_frame = receiving_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= CAPACITY_DEFAULT;
      receiving       <= 1'b0;
      prev_byte       <= '0;
      byte_count      <= '0;
      bytes_left      <= '0;
      running_sum     <= '0;
      held_type       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_len <= cfg_wr_data;
      end
      if (accept) begin
        receiving   <= receiving_next;
        prev_byte   <= prev_byte_next;
        byte_count  <= byte_count_next;
        bytes_left  <= bytes_left_next;
        running_sum <= running_sum_next;
        held_type   <= held_type_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign payload_valid    = result.payload_valid;
  assign payload_index    = result.payload_index;
  assign payload_byte     = result.payload_byte;
  assign payload_overflow = result.payload_overflow;
  assign frame_done       = result.frame_done;
  assign msg_type         = result.msg_type;
  assign frame_len        = result.frame_len;
  assign checksum_ok      = result.checksum_ok;
  assign in_frame         = result.in_frame;

endmodule

### hw/rtl/stlfr_checker.sv
// ----------------------------------------------------------------------------
// stlfr_checker
// port-level checks of the sync / type / length frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stlfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       payload_valid,
  input logic [7:0] payload_index,
  input logic [7:0] payload_byte,
  input logic       payload_overflow,
  input logic       frame_done,
  input logic [8:0] frame_len,
  input logic       in_frame
);
  import stlfr_pkg::*;

  `ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !out_valid, "out_valid after reset")
  `ASSERT_CLK(a_done_leaves_frame, clk, rst,
    out_valid && frame_done |-> !in_frame && frame_len >= FRAME_LEN_MIN,
    "closing transaction inconsistent")
  `ASSERT_CLK(a_payload_not_done, clk, rst,
    out_valid && payload_valid |-> !frame_done && in_frame,
    "payload transaction inconsistent")
  `ASSERT_CLK(a_payload_fields_zero, clk, rst,
    out_valid && !payload_valid |->
      payload_index == 8'd0 && payload_byte == 8'd0 && !payload_overflow,
    "payload fields without payload")
  `ASSERT_CLK(a_out_hold, clk, rst,
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(frame_len),
    "stalled output transaction changed")

endmodule

bind sync_type_length_frame_receiver stlfr_checker u_stlfr_checker (.*);

### sim/sync_type_length_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// sync_type_length_frame_receiver_tb
// Self-checking bench for the frame receiver. A driver feeds a queue of
// bytes (a few hand-built frames, then random frames, noise and broken
// sync attempts) under random valid gaps and output stalls. An in-bench
// predictor of the framing logic computes one expected result per
// accepted byte, and the monitor compares every field. The capacity
// register is swept through several values, 0 and 255 included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_type_length_frame_receiver_tb;
  import stlfr_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_index;
  logic [7:0] payload_byte;
  logic       payload_overflow;
  logic       frame_done;
  logic [7:0] msg_type;
  logic [8:0] frame_len;
  logic       checksum_ok;
  logic       in_frame;

  sync_type_length_frame_receiver dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic       frm_active = 1'b0;
  logic [7:0] hunt_prev = 8'h00;
  logic [8:0] frm_count = 9'd0;
  logic [7:0] frm_left = 8'h00;
  logic [7:0] frm_sum = 8'h00;
  logic [7:0] frm_type = 8'h00;
  logic [7:0] capacity = CAPACITY_DEFAULT;

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];
  result_t    next_result;
  result_t    want;

  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int payload_seen = 0;
  int overflow_seen = 0;
  int frames_seen = 0;
  int good_sums = 0;
  int settings_used = 1;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    fail_count++;
    if (fail_count <= 100)
      $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  task automatic predict_byte(input logic [7:0] b, output result_t r);
    r = '0;
    if (!frm_active) begin
      if (hunt_prev == SYNC_FIRST && b == SYNC_SECOND) begin
        frm_active = 1'b1;
        frm_count = '0;
        frm_left = '0;
        frm_sum = '0;
      end else begin
        hunt_prev = b;
      end
    end else begin
      frm_sum = frm_sum + b;
      if (frm_count == POS_TYPE) begin
        frm_type = b;
        frm_count = frm_count + 9'd1;
      end else if (frm_count == POS_LENGTH) begin
        frm_left = b;
        frm_count = frm_count + 9'd1;
      end else if (frm_left != 8'h00) begin
        r.payload_valid = 1'b1;
        r.payload_index = 8'(frm_count - HEAD_BYTES);
        r.payload_byte = b;
        r.payload_overflow = (r.payload_index >= capacity);
        frm_left = frm_left - 8'd1;
        frm_count = frm_count + 9'd1;
      end else begin
        r.frame_done = 1'b1;
        r.msg_type = frm_type;
        r.frame_len = frm_count + 9'd1;
        r.checksum_ok = (frm_sum == 8'h00);
        frm_active = 1'b0;
        hunt_prev = 8'h00;
      end
    end
    r.in_frame = frm_active;
  endtask

  function automatic logic [7:0] noise_byte();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return SYNC_FIRST;
    if (pick == 1) return SYNC_SECOND;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_frame(input logic [7:0] kind, input int n, input bit good);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] closing;
    sum = kind + 8'(n);
    pending_bytes.push_back(SYNC_FIRST);
    pending_bytes.push_back(SYNC_SECOND);
    pending_bytes.push_back(kind);
    pending_bytes.push_back(8'(n));
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      pending_bytes.push_back(b);
    end
    closing = 8'h00 - sum;
    if (!good) closing = closing + 8'($urandom_range(1, 255));
    pending_bytes.push_back(closing);
  endtask

  task automatic add_random(input int budget);
    int start;
    int pick;
    int n;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        add_frame(8'($urandom_range(0, 255)), n, $urandom_range(0, 3) != 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) pending_bytes.push_back(noise_byte());
      end else begin
        // lone sync start followed by anything
        pending_bytes.push_back(SYNC_FIRST);
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = value;
    settings_used++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(rx_byte, next_result);
        expected_results.push_back(next_result);
        bytes_sent++;
        payload_seen += next_result.payload_valid;
        overflow_seen += next_result.payload_overflow;
        frames_seen += next_result.frame_done;
        good_sums += next_result.checksum_ok;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= pending_bytes.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", payload_valid, want.payload_valid);
          if (payload_index !== want.payload_index)
            report_mismatch("payload_index", payload_index, want.payload_index);
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", payload_byte, want.payload_byte);
          if (payload_overflow !== want.payload_overflow)
            report_mismatch("payload_overflow", payload_overflow, want.payload_overflow);
          if (frame_done !== want.frame_done)
            report_mismatch("frame_done", frame_done, want.frame_done);
          if (msg_type !== want.msg_type)
            report_mismatch("msg_type", msg_type, want.msg_type);
          if (frame_len !== want.frame_len)
            report_mismatch("frame_len", frame_len, want.frame_len);
          if (checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", checksum_ok, want.checksum_ok);
          if (in_frame !== want.in_frame)
            report_mismatch("in_frame", in_frame, want.in_frame);
        end
      end
      if (stall_left > 0 && !calm) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // hand-built frames at reset capacity
    pending_bytes = '{8'h00, 8'hff, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                      8'hff, 8'h00, 8'h01,
                      SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h02, 8'hff, 8'h00, SYNC_FIRST,
                      SYNC_SECOND, SYNC_FIRST, SYNC_SECOND,
                      SYNC_FIRST, 8'h01, SYNC_SECOND, 8'h58, SYNC_SECOND};
    add_frame(8'($urandom_range(0, 255)), 45, 1'b1);
    add_random(170);

    wait_idle();
    write_capacity(8'd0);
    add_random(170);

    wait_idle();
    write_capacity(8'd255);
    add_frame(8'($urandom_range(0, 255)), 255, 1'b1);
    add_random(170);

    wait_idle();
    write_capacity(8'($urandom_range(1, 30)));
    add_random(170);

    // last part runs with no idling on either side
    wait_idle();
    write_capacity(8'($urandom_range(31, 254)));
    calm = 1'b1;
    add_random(170);

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());

    $display("sent %0d bytes under %0d capacity settings, %0d results checked",
             bytes_sent, settings_used, results_checked);
    $display("%0d payload bytes (%0d past capacity), %0d frames closed (%0d good sums)",
             payload_seen, overflow_seen, frames_seen, good_sums);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/stlfr_pkg.sv
hw/rtl/sync_type_length_frame_receiver.sv
hw/rtl/stlfr_checker.sv
sim/sync_type_length_frame_receiver_tb.sv
